>>> src/nec_ir_pkg.sv
package nec_ir_pkg;

    // default sizes
    localparam int FRAME_BITS_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    // field and register widths
    localparam int TICK_US_W   = 10;
    localparam int GAP_TICKS_W = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CODE_W      = 32;
    localparam int IDX_W       = 7;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_US   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TICKS = 1'b1;

    // register reset values
    localparam int TICK_US_RST   = 50;
    localparam int GAP_TICKS_RST = 100;

    // nominal period lengths in microseconds
    localparam int NOM_HDR_MARK  = 9000;
    localparam int NOM_HDR_SPACE = 4500;
    localparam int NOM_SHORT     = 560;
    localparam int NOM_LONG      = 1690;

    // +/-25% window, inclusive: 3n <= 4d <= 5n
    localparam int HDR_MARK_LO  = (3 * NOM_HDR_MARK + 3) / 4;
    localparam int HDR_MARK_HI  = (5 * NOM_HDR_MARK) / 4;
    localparam int HDR_SPACE_LO = (3 * NOM_HDR_SPACE + 3) / 4;
    localparam int HDR_SPACE_HI = (5 * NOM_HDR_SPACE) / 4;
    localparam int SHORT_LO     = (3 * NOM_SHORT + 3) / 4;
    localparam int SHORT_HI     = (5 * NOM_SHORT) / 4;
    localparam int LONG_LO      = (3 * NOM_LONG + 3) / 4;
    localparam int LONG_HI      = (5 * NOM_LONG) / 4;

endpackage

>>> src/nec_ir_pulse_decoder.sv
// NEC infrared pulse decoder. Each input transfer is either one pin sample
// (mode 0, ir_level 0 = mark, 1 = space) or a take-code request (mode 1),
// and each gives exactly one result: code_valid and code_value as they stand
// after the sample, or as they stood before the clear for a take-code.
// One item is taken every cycle unless the result side stalls; an item is
// first held in an input register, then its result in the result register.
// The processing stage holds the period duration multiply (ticks by tick_us)
// and the window compares. Frames following a decoded code are ignored until
// the code is taken. Configuration writes are taken at any time (ready is
// always high) and must only happen while no item is in flight.
module nec_ir_pulse_decoder #(
    parameter int FRAME_BITS  = nec_ir_pkg::FRAME_BITS_DEF,
    parameter int COUNT_WIDTH = nec_ir_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nec_ir_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [nec_ir_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic                                i_ir_level,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_code_valid,
    output logic [nec_ir_pkg::CODE_W-1:0]       o_code_value
);
    import nec_ir_pkg::*;

    localparam int FRAME_PERIODS = 2 * FRAME_BITS + 4;
    localparam int LAST_CHECKED  = 2 * FRAME_BITS + 2;
    localparam int BIT_W         = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam int DUR_W         = COUNT_WIDTH + TICK_US_W;
    localparam int CMP_W         = (COUNT_WIDTH > GAP_TICKS_W) ? COUNT_WIDTH : GAP_TICKS_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MARK  = 2'd1,
        ST_SPACE = 2'd2
    } t_level;

    // configuration registers
    logic [TICK_US_W-1:0]   r_tick_us;
    logic [GAP_TICKS_W-1:0] r_gap_ticks;

    // input stage
    logic r_in_valid;
    logic r_mode;
    logic r_level;

    // receiver state
    t_level                  r_state,       n_state;
    logic [COUNT_WIDTH-1:0]  r_tick_count,  n_tick_count;
    logic [IDX_W-1:0]        r_period_index, n_period_index;
    logic [FRAME_BITS-1:0]   r_code_word,   n_code_word;
    logic                    r_mark_ok,     n_mark_ok;
    logic                    r_frame_bad,   n_frame_bad;
    logic                    r_code_ready,  n_code_ready;

    // result stage
    logic                    r_out_valid;
    logic                    r_res_valid,   n_res_valid;
    logic [FRAME_BITS-1:0]   r_res_code,    n_res_code;

    logic                    fire;
    logic [COUNT_WIDTH-1:0]  tick_inc;
    logic [DUR_W-1:0]        dur_us;
    logic                    win_hdr_mark;
    logic                    win_hdr_space;
    logic                    win_short;
    logic                    win_long;
    logic                    gap_reached;
    logic [IDX_W-1:0]        idx_inc;
    logic [BIT_W-1:0]        bit_sel;

    // handshake
    assign fire        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    // saturating tick and period duration
    assign tick_inc    = (r_tick_count < COUNT_MAX) ? r_tick_count + 1'b1 : r_tick_count;
    assign dur_us      = DUR_W'(tick_inc) * DUR_W'(r_tick_us);
    assign gap_reached = CMP_W'(tick_inc) >= CMP_W'(r_gap_ticks);

    // window checks
    assign win_hdr_mark  = (dur_us >= DUR_W'(HDR_MARK_LO))  && (dur_us <= DUR_W'(HDR_MARK_HI));
    assign win_hdr_space = (dur_us >= DUR_W'(HDR_SPACE_LO)) && (dur_us <= DUR_W'(HDR_SPACE_HI));
    assign win_short     = (dur_us >= DUR_W'(SHORT_LO))     && (dur_us <= DUR_W'(SHORT_HI));
    assign win_long      = (dur_us >= DUR_W'(LONG_LO))      && (dur_us <= DUR_W'(LONG_HI));

    assign idx_inc = r_period_index + 1'b1;
    assign bit_sel = BIT_W'(r_period_index[IDX_W-1:1] - (IDX_W-1)'(2));

    // next receiver state
    always_comb begin
        logic   do_store;
        logic   do_clear;
        t_level store_next;

        do_store   = 1'b0;
        do_clear   = 1'b0;
        store_next = ST_MARK;

        n_state        = r_state;
        n_tick_count   = tick_inc;
        n_period_index = r_period_index;
        n_code_word    = r_code_word;
        n_mark_ok      = r_mark_ok;
        n_frame_bad    = r_frame_bad;
        n_code_ready   = r_code_ready;

        if (r_mode) begin
            do_clear = 1'b1;
        end else begin
            case (r_state)
                ST_MARK: begin
                    if (r_level) begin
                        do_store   = 1'b1;
                        store_next = ST_SPACE;
                    end
                end
                ST_SPACE: begin
                    if (!r_level) begin
                        do_store   = 1'b1;
                        store_next = ST_MARK;
                    end else if (gap_reached) begin
                        if (r_period_index == IDX_W'(FRAME_PERIODS) && !r_frame_bad) begin
                            n_code_ready = 1'b1;
                            n_state      = ST_IDLE;
                        end else begin
                            do_clear = 1'b1;
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                    if (!r_level) begin
                        if (!gap_reached || r_code_ready) begin
                            n_tick_count = '0;
                        end else begin
                            do_store   = 1'b1;
                            store_next = ST_MARK;
                        end
                    end
                end
            endcase
        end

        // check the period that just ended
        if (do_store) begin
            if (r_period_index == IDX_W'(1)) begin
                if (!win_hdr_mark) n_frame_bad = 1'b1;
            end else if (r_period_index == IDX_W'(2)) begin
                if (!win_hdr_space) n_frame_bad = 1'b1;
            end else if (r_period_index >= IDX_W'(3) &&
                         r_period_index <= IDX_W'(LAST_CHECKED)) begin
                if (r_period_index[0]) begin
                    n_mark_ok = win_short;
                end else if (r_mark_ok && win_long) begin
                    n_code_word = r_code_word | (FRAME_BITS'(1) << bit_sel);
                end else if (!(r_mark_ok && win_short)) begin
                    n_frame_bad = 1'b1;
                end
            end

            if (idx_inc > IDX_W'(FRAME_PERIODS)) begin
                do_clear = 1'b1;
            end else begin
                n_tick_count   = '0;
                n_period_index = idx_inc;
                n_state        = store_next;
            end
        end

        // receiver restart
        if (do_clear) begin
            n_state        = ST_IDLE;
            n_tick_count   = '0;
            n_period_index = '0;
            n_code_word    = '0;
            n_mark_ok      = 1'b0;
            n_frame_bad    = 1'b0;
            n_code_ready   = 1'b0;
        end
    end

    // result: take-code shows the values before the clear
    always_comb begin
        if (r_mode) begin
            n_res_valid = r_code_ready;
            n_res_code  = r_code_ready ? r_code_word : '0;
        end else begin
            n_res_valid = n_code_ready;
            n_res_code  = n_code_ready ? n_code_word : '0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_us   <= TICK_US_W'(TICK_US_RST);
            r_gap_ticks <= GAP_TICKS_W'(GAP_TICKS_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TICK_US:   r_tick_us   <= i_cfg_data[TICK_US_W-1:0];
                CFG_GAP_TICKS: r_gap_ticks <= i_cfg_data[GAP_TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_mode  <= i_mode;
            r_level <= i_ir_level;
        end
    end

    // receiver state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_tick_count   <= '0;
            r_period_index <= '0;
            r_code_word    <= '0;
            r_mark_ok      <= 1'b0;
            r_frame_bad    <= 1'b0;
            r_code_ready   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (fire) begin
                r_state        <= n_state;
                r_tick_count   <= n_tick_count;
                r_period_index <= n_period_index;
                r_code_word    <= n_code_word;
                r_mark_ok      <= n_mark_ok;
                r_frame_bad    <= n_frame_bad;
                r_code_ready   <= n_code_ready;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res_valid <= n_res_valid;
            r_res_code  <= n_res_code;
        end
    end

    assign o_code_valid = r_res_valid;
    assign o_code_value = CODE_W'(r_res_code);

    // period count never runs past a full frame
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period_index <= IDX_W'(FRAME_PERIODS))
        else $error("period index beyond frame length");

    // a waiting code parks the receiver in idle with a full frame stored
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_code_ready |-> (r_state == ST_IDLE && r_period_index == IDX_W'(FRAME_PERIODS)))
        else $error("code ready outside idle or with partial frame");

    // take-code restarts the receiver
    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_mode) |=> (!r_code_ready && r_period_index == '0 && r_tick_count == '0))
        else $error("take-code did not restart receiver");

    // input side only stalls on a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule
